// ===== hw/rtl/hbf_pkg.sv =====
`default_nettype none

package hbf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxModesDefault = 256;
  localparam int unsigned FracBitsDefault = 16;

  // Field widths fixed by the interface
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW    = 48;
  localparam int unsigned WideW   = 52;

  // Reset value of the mass register: 1.0 in Q16.16
  localparam logic [31:0] MassReset = 32'h0001_0000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE_COUNT = 3'd0,
    CFG_MASS       = 3'd1,
    CFG_GAMMA      = 3'd2,
    CFG_COUPLING   = 3'd3,
    CFG_SPACING    = 3'd4
  } cfg_reg_e;

  // Multiplier operations of one mode, in issue order
  typedef enum logic [3:0] {
    OP_OMEGA,
    OP_OM2,
    OP_MW2,
    OP_C,
    OP_CQ,
    OP_CX,
    OP_MX,
    OP_GQ,
    OP_XX,
    OP_T1,
    OP_T2,
    OP_QQ,
    OP_T3
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul_lo;
    logic mul_hi;
    logic fin;
    logic eval;
    logic acc;
    logic load_out;
    op_e  op;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active;
  } status_t;

  // Operations whose first operand is a 48-bit product need a second pass
  function automatic logic op_is_wide(op_e op);
    return (op == OP_T1) || (op == OP_T2) || (op == OP_T3);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hbf_ctrl.sv =====
`default_nettype none

module hbf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire hbf_pkg::status_t status_i,
  output hbf_pkg::cmd_t        cmd_o
);
  import hbf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MULH,
    ST_FIN,
    ST_EVAL,
    ST_ACC,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d          = OP_OMEGA;
          state_d       = status_i.active ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = op_is_wide(op_q) ? ST_MULH : ST_FIN;
      end
      ST_MULH: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        if (op_q == OP_T3) begin
          state_d = ST_EVAL;
        end else begin
          op_d    = op_e'(op_q + 4'd1);
          state_d = ST_MUL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the output valid until the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_OMEGA;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting result");

  // An inactive item goes straight to the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_in && !status_i.active) |=> (state_q == ST_OUT))
    else $error("inactive item entered the multiply sequence");

  // Every multiply sequence starts from the first operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_in && status_i.active) |=> (op_q == OP_OMEGA && state_q == ST_MUL))
    else $error("multiply sequence started mid-way");

endmodule

`default_nettype wire

// ===== hw/rtl/hbf_datapath.sv =====
`default_nettype none

module hbf_datapath #(
  parameter int unsigned MAX_MODES = hbf_pkg::MaxModesDefault,
  parameter int unsigned FRAC_BITS = hbf_pkg::FracBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [hbf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic signed [hbf_pkg::CoordW-1:0] system_coord_i,
  input  wire logic signed [hbf_pkg::CoordW-1:0] bath_coord_i,
  input  wire logic                          last_in_i,
  input  wire hbf_pkg::cmd_t                 cmd_i,
  output hbf_pkg::status_t                   status_o,
  output logic signed [hbf_pkg::CoordW-1:0]  mode_force_o,
  output logic signed [hbf_pkg::CoordW-1:0]  system_force_o,
  output logic signed [hbf_pkg::CoordW-1:0]  energy_o,
  output logic                               last_out_o
);
  import hbf_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_MODES + 1);
  localparam logic [46:0] MagMax = {47{1'b1}};
  // Reset mass of 1.0 at the chosen fraction width
  localparam logic [31:0] MassOne = 32'(64'd1 << FRAC_BITS);

  // Saturate a wide signed value to the 48-bit sum range
  function automatic logic signed [SumW-1:0] sat_sum(logic signed [WideW-1:0] v);
    logic signed [SumW-1:0] r;
    if ((&v[WideW-1:SumW-1]) || !(|v[WideW-1:SumW-1])) begin
      r = v[SumW-1:0];
    end else begin
      r = v[WideW-1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a wide signed value to a 32-bit result
  function automatic logic signed [31:0] sat32(logic signed [WideW-1:0] v);
    logic signed [31:0] r;
    if ((&v[WideW-1:31]) || !(|v[WideW-1:31])) begin
      r = v[31:0];
    end else begin
      r = v[WideW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [47:0] abs48(logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [WideW-1:0] ext(logic signed [SumW-1:0] v);
    return {{(WideW-SumW){v[SumW-1]}}, v};
  endfunction

  // Configuration registers
  logic [CountW-1:0] mode_count_q;
  logic [31:0]       mass_q, gamma_q, coupling_q, spacing_q;

  // Item and run state
  logic signed [31:0] q_q, x_q;
  logic               last_q;
  logic [IdxW-1:0]    mode_index_q;
  logic signed [SumW-1:0] force_sum_q, energy_sum_q;

  // Per-mode intermediate results
  logic [31:0]            omega_q, om2_q, mw2_q, c_q;
  logic signed [SumW-1:0] cq_q, cx_q, mx_q, gq_q, xx_q, t1_q, t2_q, qq_q, t3_q;
  logic signed [WideW-1:0] e_q, df_q;
  logic signed [31:0]     fm_q;

  // Multiplier state
  logic [63:0] p_lo_q;
  logic [47:0] p_hi_q;
  logic        sign_q;

  // Output register
  logic signed [31:0] out_fm_q, out_force_q, out_energy_q;
  logic               out_last_q;

  assign status_o.active = ({{(32-IdxW){1'b0}}, mode_index_q} < 32'(mode_count_q)) &&
                           ({{(32-IdxW){1'b0}}, mode_index_q} < 32'(MAX_MODES));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= '0;
      mass_q       <= MassOne;
      gamma_q      <= '0;
      coupling_q   <= '0;
      spacing_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MODE_COUNT: mode_count_q <= cfg_data_i[CountW-1:0];
        CFG_MASS:       mass_q       <= cfg_data_i;
        CFG_GAMMA:      gamma_q      <= cfg_data_i;
        CFG_COUPLING:   coupling_q   <= cfg_data_i;
        CFG_SPACING:    spacing_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Select multiplier operands by operation
  logic [47:0] a_mag;
  logic [31:0] b_mag;
  logic        a_neg, b_neg, op_half;

  always_comb begin
    a_mag   = '0;
    b_mag   = '0;
    a_neg   = 1'b0;
    b_neg   = 1'b0;
    op_half = 1'b0;
    unique case (cmd_i.op)
      OP_OMEGA: begin
        a_mag   = 48'({mode_index_q, 1'b1});
        b_mag   = spacing_q;
        op_half = 1'b1;
      end
      OP_OM2: begin
        a_mag  = 48'(omega_q);
        b_mag  = omega_q;
      end
      OP_MW2: begin
        a_mag  = 48'(mass_q);
        b_mag  = om2_q;
      end
      OP_C: begin
        a_mag  = 48'(coupling_q);
        b_mag  = omega_q;
      end
      OP_CQ: begin
        a_mag = 48'(abs32(q_q));
        a_neg = q_q[31];
        b_mag = c_q;
      end
      OP_CX: begin
        a_mag = 48'(abs32(x_q));
        a_neg = x_q[31];
        b_mag = c_q;
      end
      OP_MX: begin
        a_mag = 48'(abs32(x_q));
        a_neg = x_q[31];
        b_mag = mw2_q;
      end
      OP_GQ: begin
        a_mag = 48'(abs32(q_q));
        a_neg = q_q[31];
        b_mag = gamma_q;
      end
      OP_XX: begin
        a_mag = 48'(abs32(x_q));
        b_mag = abs32(x_q);
      end
      OP_T1: begin
        a_mag = abs48(xx_q);
        a_neg = xx_q[SumW-1];
        b_mag = mw2_q;
      end
      OP_T2: begin
        a_mag = abs48(cx_q);
        a_neg = cx_q[SumW-1];
        b_mag = abs32(q_q);
        b_neg = q_q[31];
      end
      OP_QQ: begin
        a_mag = 48'(abs32(q_q));
        b_mag = abs32(q_q);
      end
      OP_T3: begin
        a_mag = abs48(qq_q);
        a_neg = qq_q[SumW-1];
        b_mag = gamma_q;
      end
      default: ;
    endcase
  end

  // Scale, saturate and sign the finished product
  logic [79:0]            full_prod, shifted;
  logic [46:0]            res_mag;
  logic signed [SumW-1:0] res_signed;
  logic [31:0]            res_cap;

  always_comb begin
    full_prod  = {16'b0, p_lo_q} + {p_hi_q, 32'b0};
    shifted    = op_half ? (full_prod >> 1) : (full_prod >> FRAC_BITS);
    res_mag    = (|shifted[79:47]) ? MagMax : shifted[46:0];
    res_signed = sign_q ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
    res_cap    = (|res_mag[46:32]) ? 32'hFFFF_FFFF : res_mag[31:0];
  end

  // Per-mode sums of the finished products
  logic signed [WideW-1:0] e_raw, e_adj;

  always_comb begin
    e_raw = ext(t1_q) - {{(WideW-SumW-1){t2_q[SumW-1]}}, t2_q, 1'b0} + ext(t3_q);
    e_adj = e_raw + {{(WideW-1){1'b0}}, e_raw[WideW-1]};
  end

  // Multiplier passes and intermediate registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      q_q    <= system_coord_i;
      x_q    <= bath_coord_i;
      last_q <= last_in_i;
      fm_q   <= '0;
    end
    if (cmd_i.mul_lo) begin
      p_lo_q <= 64'(a_mag[31:0]) * 64'(b_mag);
      p_hi_q <= '0;
      sign_q <= a_neg ^ b_neg;
    end
    if (cmd_i.mul_hi) begin
      p_hi_q <= 48'(a_mag[47:32]) * 48'(b_mag);
    end
    if (cmd_i.fin) begin
      unique case (cmd_i.op)
        OP_OMEGA: omega_q <= res_cap;
        OP_OM2:   om2_q   <= res_cap;
        OP_MW2:   mw2_q   <= res_cap;
        OP_C:     c_q     <= res_cap;
        OP_CQ:    cq_q    <= res_signed;
        OP_CX:    cx_q    <= res_signed;
        OP_MX:    mx_q    <= res_signed;
        OP_GQ:    gq_q    <= res_signed;
        OP_XX:    xx_q    <= res_signed;
        OP_T1:    t1_q    <= res_signed;
        OP_T2:    t2_q    <= res_signed;
        OP_QQ:    qq_q    <= res_signed;
        OP_T3:    t3_q    <= res_signed;
        default: ;
      endcase
    end
    if (cmd_i.eval) begin
      fm_q <= sat32(ext(cq_q) - ext(mx_q));
      df_q <= ext(cx_q) - ext(gq_q);
      e_q  <= e_adj >>> 1;
    end
    if (cmd_i.load_out) begin
      out_fm_q     <= fm_q;
      out_force_q  <= sat32(ext(force_sum_q));
      out_energy_q <= sat32(ext(energy_sum_q));
      out_last_q   <= last_q;
    end
  end

  // Accumulate totals, clear them after the last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_index_q <= IdxW'(1);
      force_sum_q  <= '0;
      energy_sum_q <= '0;
    end else if (cmd_i.load_out && last_q) begin
      mode_index_q <= IdxW'(1);
      force_sum_q  <= '0;
      energy_sum_q <= '0;
    end else if (cmd_i.acc) begin
      mode_index_q <= mode_index_q + IdxW'(1);
      force_sum_q  <= sat_sum(ext(force_sum_q) + df_q);
      energy_sum_q <= sat_sum(ext(energy_sum_q) + e_q);
    end
  end

  assign mode_force_o   = out_fm_q;
  assign system_force_o = out_force_q;
  assign energy_o       = out_energy_q;
  assign last_out_o     = out_last_q;

  // The mode index stays within one and the mode limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_index_q != '0) && ({{(32-IdxW){1'b0}}, mode_index_q} <= 32'(MAX_MODES)))
    else $error("mode index out of range");

  // Totals only advance for a mode below the mode count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc |-> status_o.active)
    else $error("totals advanced for an inactive mode");

  // A last item leaves the run cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && last_q) |=>
      (force_sum_q == '0 && energy_sum_q == '0 && mode_index_q == IdxW'(1)))
    else $error("run state not cleared after last item");

endmodule

`default_nettype wire

// ===== hw/rtl/harmonic_bath_force_top.sv =====
`default_nettype none

// Channel      Direction  Handshake                      Payload
// s_axis       in         s_axis_tvalid / s_axis_tready  tdata: system_coord, bath_coord;
//                                                         tlast: last_in
// m_axis       out        m_axis_tvalid / m_axis_tready  tdata: mode_force, system_force,
//                                                         energy; tlast: last_out
// cfg          in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// An active mode runs thirteen operations in turn, a 32x32 multiply each, plus a
// 16x32 multiply for the upper bits of a 48-bit operand, then evaluates and accumulates.
// An item past the mode count goes straight to the output. One item is in work at a time;
// a finished result waits in the output register while the next is taken.
// Reset is asynchronous and active low; configuration is always ready.
module harmonic_bath_force_top #(
  parameter int unsigned MAX_MODES = hbf_pkg::MaxModesDefault,
  parameter int unsigned FRAC_BITS = hbf_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [31:0] system_coord, [63:32] bath_coord
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] mode_force, [63:32] system_force, [95:64] energy
  output logic [95:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [hbf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import hbf_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic signed [31:0] mode_force, system_force, energy;

  assign cfg_ready_o = 1'b1;

  hbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hbf_datapath #(
    .MAX_MODES (MAX_MODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .system_coord_i (s_axis_tdata[31:0]),
    .bath_coord_i   (s_axis_tdata[63:32]),
    .last_in_i      (s_axis_tlast),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_force_o   (mode_force),
    .system_force_o (system_force),
    .energy_o       (energy),
    .last_out_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {energy, system_force, mode_force};

endmodule

`default_nettype wire

// ===== dv/harmonic_bath_force_checker.sv =====
`timescale 1ns / 1ps

module harmonic_bath_force_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // [31:0] system_coord, [63:32] bath_coord
  input  logic [63:0]                  s_axis_tdata,
  input  logic                         s_axis_tlast,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // [31:0] mode_force, [63:32] system_force, [95:64] energy
  input  logic [95:0]                  m_axis_tdata,
  input  logic                         m_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [hbf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o
);

  import hbf_pkg::*;

  localparam int unsigned MaxModes = MaxModesDefault;
  localparam int unsigned FracBits = FracBitsDefault;
  localparam longint SumMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;
  localparam longint U32Max = 64'sh0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] mode_force;
    logic [31:0] system_force;
    logic [31:0] energy;
    logic        last;
  } bath_result_t;

  // Mirrored registers
  logic [8:0]  mode_count_q;
  logic [31:0] mass_q;
  logic [31:0] gamma_q;
  logic [31:0] coupling_q;
  logic [31:0] spacing_q;

  // Mirrored evaluation state
  int unsigned mode_idx;
  longint      energy_acc;
  longint      force_acc;

  bath_result_t bath_results_due[$];
  int unsigned  result_no;

  // Q16.16 product, truncated toward zero, magnitude held to 2^47-1
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = ({64'd0, ua} * {64'd0, ub}) >> FracBits;
    if (prod > 128'(SumMax)) prod = 128'(SumMax);
    return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint cap_u32(longint v);
    return (v > U32Max) ? U32Max : v;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > SumMax) return SumMax;
    if (v < SumMin) return SumMin;
    return v;
  endfunction

  function automatic logic [31:0] to_q16(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Advance the bath by one request and give the result it should produce
  function automatic bath_result_t bath_force_step(logic [31:0] q_bits, logic [31:0] x_bits,
                                                   logic last);
    longint       q, x, w, omega, om2, mw2, c;
    longint       cq, cx, mx, gq, t1, t2, t3, e, fm;
    int unsigned  count;
    bath_result_t r;
    q = longint'(signed'(q_bits));
    x = longint'(signed'(x_bits));
    count = (mode_count_q > MaxModes) ? MaxModes : mode_count_q;
    fm = 0;
    // Active mode: derive the mode constants, then the force and energy terms
    if (mode_idx < count) begin
      w = ((2 * longint'(mode_idx) + 1) * longint'(spacing_q)) >>> 1;
      omega = cap_u32(w);
      om2 = cap_u32(fx_mul(omega, omega));
      mw2 = cap_u32(fx_mul(longint'(mass_q), om2));
      c = cap_u32(fx_mul(longint'(coupling_q), omega));
      cq = fx_mul(c, q);
      cx = fx_mul(c, x);
      mx = fx_mul(mw2, x);
      gq = fx_mul(longint'(gamma_q), q);
      t1 = fx_mul(fx_mul(x, x), mw2);
      t2 = fx_mul(cx, q);
      t3 = fx_mul(fx_mul(q, q), longint'(gamma_q));
      e = (t1 - 2 * t2 + t3) / 2;
      fm = cq - mx;
      force_acc = clamp48(force_acc + (cx - gq));
      energy_acc = clamp48(energy_acc + e);
      mode_idx++;
    end
    r.mode_force = to_q16(fm);
    r.system_force = to_q16(force_acc);
    r.energy = to_q16(energy_acc);
    r.last = last;
    // Close the evaluation
    if (last) begin
      mode_idx = 1;
      force_acc = 0;
      energy_acc = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Compare one delivered result with the oldest outstanding one
  task automatic check_result();
    bath_result_t got;
    bath_result_t want;
    got.mode_force = m_axis_tdata[31:0];
    got.system_force = m_axis_tdata[63:32];
    got.energy = m_axis_tdata[95:64];
    got.last = m_axis_tlast;
    if (bath_results_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no request outstanding", result_no));
    end else begin
      want = bath_results_due.pop_front();
      if (got.mode_force !== want.mode_force)
        report_mismatch($sformatf("result %0d mode_force %h, expected %h",
                                  result_no, got.mode_force, want.mode_force));
      if (got.system_force !== want.system_force)
        report_mismatch($sformatf("result %0d system_force %h, expected %h",
                                  result_no, got.system_force, want.system_force));
      if (got.energy !== want.energy)
        report_mismatch($sformatf("result %0d energy %h, expected %h",
                                  result_no, got.energy, want.energy));
      if (got.last !== want.last)
        report_mismatch($sformatf("result %0d last_out %b, expected %b",
                                  result_no, got.last, want.last));
    end
    result_no++;
  endtask

  // Watch all three channels; results are taken before new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q = 9'd0;
      mass_q = MassReset;
      gamma_q = 32'd0;
      coupling_q = 32'd0;
      spacing_q = 32'd0;
      mode_idx = 1;
      energy_acc = 0;
      force_acc = 0;
      bath_results_due.delete();
      result_no = 0;
      mismatch_count_o = 0;
      pending_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        bath_results_due.push_back(bath_force_step(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                   s_axis_tlast));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MODE_COUNT: mode_count_q = cfg_data_i[8:0];
          CFG_MASS:       mass_q = cfg_data_i;
          CFG_GAMMA:      gamma_q = cfg_data_i;
          CFG_COUPLING:   coupling_q = cfg_data_i;
          CFG_SPACING:    spacing_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_count_o <= bath_results_due.size();
    end
  end

endmodule

// ===== dv/harmonic_bath_force_top_tb.sv =====
`timescale 1ns / 1ps

module harmonic_bath_force_top_tb;

  import hbf_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned ClampFrame = 258;
  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;
  localparam logic [31:0] One  = 32'h0001_0000;
  localparam logic [31:0] Full = 32'hFFFF_FFFF;

  logic                clk_i;
  logic                rst_ni;
  logic [63:0]         s_axis_tdata;
  logic                s_axis_tlast;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [95:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [31:0]         cfg_data_i;

  int          mismatch_count;
  int          pending_count;
  bit          hold_request;
  int unsigned burst_left;

  harmonic_bath_force_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  harmonic_bath_force_checker u_bath_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: switch between stall styles, and hold off for a long stretch on demand
  initial begin
    int unsigned style;
    int unsigned span;
    style = 0;
    span = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (span % 5 != 0);
        endcase
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return QMax;
      1: return QMin;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Mostly modest register values, now and then anything at all
  function automatic logic [31:0] rand_reg(logic [31:0] modest_max);
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, modest_max);
  endfunction

  // Mostly a complete evaluation; sometimes cut short or run past the mode count
  function automatic int unsigned pick_frame_len(int unsigned count_eff);
    int unsigned full;
    full = (count_eff > 1) ? count_eff - 1 : 1;
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(1, full);
      2: return full + $urandom_range(1, 3);
      default: return full;
    endcase
  endfunction

  // Offer one request, possibly idling first when a burst has run out
  task automatic send_bath(logic [31:0] q, logic [31:0] x, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {x, q};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_frame(int unsigned len, bit close);
    logic [31:0] q;
    q = rand_coord();
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) q = rand_coord();
      send_bath(q, rand_coord(), close && (i == len - 1));
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(logic [8:0] count, logic [31:0] m, logic [31:0] g,
                               logic [31:0] k, logic [31:0] sp);
    write_reg(CFG_MODE_COUNT, {23'd0, count});
    write_reg(CFG_MASS, m);
    write_reg(CFG_GAMMA, g);
    write_reg(CFG_COUPLING, k);
    write_reg(CFG_SPACING, sp);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [8:0]  count;
    int unsigned count_eff;
    int unsigned sent;
    int unsigned len;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_MODE_COUNT;
    cfg_data_i <= '0;
    hold_request = 1'b0;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: no modes, so every result is zero
    send_bath(QMax, QMin, 1'b0);
    send_bath(QMin, QMax, 1'b1);

    // Four modes: extreme coordinates, then requests past the mode count
    drain_results();
    apply_setting(9'd4, One, 32'h0000_8000, 32'h0000_B505, One);
    send_bath(32'h0001_8000, 32'h0000_0000, 1'b0);
    send_bath(QMax, QMin, 1'b0);
    send_bath(QMin, QMax, 1'b0);
    send_bath(QMin, QMin, 1'b0);
    send_bath(32'h0000_0000, 32'hFFFF_0000, 1'b1);
    send_bath(One, One, 1'b1);

    // Every register at its maximum: saturate omega, products and totals
    drain_results();
    apply_setting(9'd256, Full, Full, Full, Full);
    send_bath(QMax, QMax, 1'b0);
    send_bath(QMin, QMin, 1'b0);
    send_bath(QMax, QMin, 1'b0);
    send_bath(QMin, QMax, 1'b0);
    send_bath(32'h0000_0000, 32'h0000_0000, 1'b1);

    // Zero registers, then a new setting in the middle of an open evaluation
    drain_results();
    apply_setting(9'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    send_bath(QMax, QMax, 1'b0);
    drain_results();
    apply_setting(9'd3, One, One, One, 32'h0000_4000);
    send_bath(One, QMin, 1'b0);
    send_bath(One, One, 1'b1);

    // Random settings; one phase runs past the clamp on the mode count
    for (int unsigned ph = 0; ph < 9; ph++) begin
      drain_results();
      if (ph == 4) begin
        count = 9'h1FF;
      end else begin
        case ($urandom_range(0, 7))
          0: count = 9'd0;
          1: count = 9'd1;
          2: count = 9'd2;
          7: count = 9'($urandom_range(13, 40));
          default: count = 9'($urandom_range(3, 12));
        endcase
      end
      count_eff = (count > MaxModesDefault) ? MaxModesDefault : count;
      apply_setting(count, rand_reg(32'h0004_0000), rand_reg(32'h0002_0000),
                    rand_reg(32'h0002_0000), rand_reg(32'h0002_0000));
      if (ph == 2) hold_request = 1'b1;
      if (ph == 4) begin
        send_frame(ClampFrame, 1'b1);
      end else begin
        sent = 0;
        while (sent < 28) begin
          len = pick_frame_len(count_eff);
          send_frame(len, $urandom_range(0, 5) != 0);
          sent += len;
        end
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hbf_pkg.sv
hw/rtl/hbf_ctrl.sv
hw/rtl/hbf_datapath.sv
hw/rtl/harmonic_bath_force_top.sv
dv/harmonic_bath_force_checker.sv
dv/harmonic_bath_force_top_tb.sv
